@@ src/cdrle_pkg.sv @@
// types, constants and step table for the little-endian cdr deserializer
// no dependencies; imported by cdr_le_message_deserializer_core
`timescale 1ns / 1ps
package cdrle_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [3:0]  field_code;
    logic [31:0] field_value;
    logic [1:0]  parse_status;
    logic        run_last;
  } out_item_t;

  // kind of one parse step
  typedef enum logic [2:0] {
    K_DONE    = 3'd0,
    K_U32     = 3'd1,
    K_U8      = 3'd2,
    K_BOOL    = 3'd3,
    K_STRBODY = 3'd4,
    K_SEQBODY = 3'd5
  } step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [3:0] code;
  } step_desc_t;

  // layout register codes
  localparam logic [1:0] LAYOUT_RAW  = 2'd0;
  localparam logic [1:0] LAYOUT_H264 = 2'd1;
  localparam logic [1:0] LAYOUT_COMP = 2'd2;

  // field codes
  localparam logic [3:0] FC_SEC       = 4'd0;
  localparam logic [3:0] FC_NANOSEC   = 4'd1;
  localparam logic [3:0] FC_FRAME_LEN = 4'd2;
  localparam logic [3:0] FC_FRAME_CHR = 4'd3;
  localparam logic [3:0] FC_HEIGHT    = 4'd4;
  localparam logic [3:0] FC_WIDTH     = 4'd5;
  localparam logic [3:0] FC_ENC_LEN   = 4'd6;
  localparam logic [3:0] FC_ENC_CHR   = 4'd7;
  localparam logic [3:0] FC_BIGENDIAN = 4'd8;
  localparam logic [3:0] FC_STEP      = 4'd9;
  localparam logic [3:0] FC_DATA_LEN  = 4'd10;
  localparam logic [3:0] FC_DATA_BYTE = 4'd11;
  localparam logic [3:0] FC_KEYFRAME  = 4'd12;
  localparam logic [3:0] FC_FMT_LEN   = 4'd13;
  localparam logic [3:0] FC_FMT_CHR   = 4'd14;
  localparam logic [3:0] FC_END       = 4'd15;

  // parse status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_LE    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // header constants
  localparam logic [7:0] LE_MARK    = 8'h01;
  localparam logic [2:0] HEADER_LEN = 3'd4;
  localparam logic [3:0] STEP_LAST  = 4'd15;

  function automatic step_desc_t mk(input step_kind_t k, input logic [3:0] c);
    step_desc_t d;
    d.kind = k;
    d.code = c;
    return d;
  endfunction

  // step list of each layout; unused codes fall back to raw image
  function automatic step_desc_t step_lookup(input logic [1:0] layout,
                                             input logic [3:0] step);
    step_desc_t d;
    d = mk(K_DONE, FC_SEC);
    case (layout)
      LAYOUT_H264: begin
        case (step)
          4'd0:    d = mk(K_U32, FC_SEC);
          4'd1:    d = mk(K_U32, FC_NANOSEC);
          4'd2:    d = mk(K_U32, FC_FRAME_LEN);
          4'd3:    d = mk(K_STRBODY, FC_FRAME_CHR);
          4'd4:    d = mk(K_U32, FC_WIDTH);
          4'd5:    d = mk(K_U32, FC_HEIGHT);
          4'd6:    d = mk(K_BOOL, FC_KEYFRAME);
          4'd7:    d = mk(K_U32, FC_DATA_LEN);
          4'd8:    d = mk(K_SEQBODY, FC_DATA_BYTE);
          default: d = mk(K_DONE, FC_SEC);
        endcase
      end
      LAYOUT_COMP: begin
        case (step)
          4'd0:    d = mk(K_U32, FC_SEC);
          4'd1:    d = mk(K_U32, FC_NANOSEC);
          4'd2:    d = mk(K_U32, FC_FRAME_LEN);
          4'd3:    d = mk(K_STRBODY, FC_FRAME_CHR);
          4'd4:    d = mk(K_U32, FC_DATA_LEN);
          4'd5:    d = mk(K_SEQBODY, FC_DATA_BYTE);
          4'd6:    d = mk(K_U32, FC_FMT_LEN);
          4'd7:    d = mk(K_STRBODY, FC_FMT_CHR);
          default: d = mk(K_DONE, FC_SEC);
        endcase
      end
      default: begin
        case (step)
          4'd0:    d = mk(K_U32, FC_SEC);
          4'd1:    d = mk(K_U32, FC_NANOSEC);
          4'd2:    d = mk(K_U32, FC_FRAME_LEN);
          4'd3:    d = mk(K_STRBODY, FC_FRAME_CHR);
          4'd4:    d = mk(K_U32, FC_HEIGHT);
          4'd5:    d = mk(K_U32, FC_WIDTH);
          4'd6:    d = mk(K_U32, FC_ENC_LEN);
          4'd7:    d = mk(K_STRBODY, FC_ENC_CHR);
          4'd8:    d = mk(K_U8, FC_BIGENDIAN);
          4'd9:    d = mk(K_U32, FC_STEP);
          4'd10:   d = mk(K_U32, FC_DATA_LEN);
          4'd11:   d = mk(K_SEQBODY, FC_DATA_BYTE);
          default: d = mk(K_DONE, FC_SEC);
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

@@ src/cdr_le_message_deserializer_core.sv @@
// little-endian plain cdr message deserializer, one byte per transaction
// depends on cdrle_pkg (payload types, field codes, step table)
`timescale 1ns / 1ps
// A result is registered in the result queue and is on out_data in the cycle after its byte
//   is accepted when no earlier result is waiting in the result queue.
// Throughput: one byte per cycle while in_ready is high; a byte that also ends the message
//   gives two results, and the result queue absorbs the extra one.
// in_ready is high while the result queue has room for two results.
// Reset (rst_n low, synchronous): parse state cleared, layout register to raw
//   image, result queue emptied.
module cdr_le_message_deserializer_core #(
  parameter int QDEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cdrle_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cdrle_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data
);
  import cdrle_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  // configuration and parse state
  logic [1:0]  layout_r;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [1:0]  body_off_r, body_off_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [1:0]  sbi_r, sbi_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        err_r, err_nxt;

  // result queue, head at entry 0
  out_item_t   q_r [QDEPTH];
  out_item_t   q_nxt [QDEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic        in_fire, pop;
  out_item_t   res0, res1;
  logic [1:0]  nres;

  assign in_ready  = cnt_r <= CW'(QDEPTH - 2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;

  // per-byte parse step
  always_comb begin
    step_desc_t cur;
    step_desc_t nxt_d;
    logic       fld_emit;
    logic [3:0] fld_code;
    logic [31:0] fld_val;
    logic [31:0] asm_new;
    logic [31:0] rem_dec;
    logic [1:0]  status;

    hdr_cnt_nxt  = hdr_cnt_r;
    body_off_nxt = body_off_r;
    step_nxt     = step_r;
    sbi_nxt      = sbi_r;
    asm_nxt      = asm_r;
    rem_nxt      = rem_r;
    err_nxt      = err_r;
    fld_emit     = 1'b0;
    fld_code     = FC_SEC;
    fld_val      = '0;
    status       = ST_OK;
    res0         = '0;
    res1         = '0;
    nres         = 2'd0;
    cur          = step_lookup(layout_r, step_r);
    nxt_d        = cur;
    asm_new      = '0;
    rem_dec      = rem_r - 32'd1;

    if (hdr_cnt_r < HEADER_LEN) begin
      // encapsulation header
      if (hdr_cnt_r == 3'd1 && in_data.data_byte != LE_MARK) begin
        err_nxt = 1'b1;
      end
      hdr_cnt_nxt = hdr_cnt_r + 3'd1;
    end else if (!err_r) begin
      body_off_nxt = body_off_r + 2'd1;
      case (cur.kind)
        K_U32: begin
          if (!(sbi_r == 2'd0 && body_off_r != 2'd0)) begin
            if (sbi_r == 2'd0) begin
              asm_new = {24'd0, in_data.data_byte};
            end else begin
              asm_new = asm_r | ({24'd0, in_data.data_byte} << {sbi_r, 3'b000});
            end
            asm_nxt = asm_new;
            if (sbi_r == 2'd3) begin
              sbi_nxt  = 2'd0;
              fld_emit = 1'b1;
              fld_code = cur.code;
              fld_val  = asm_new;
              if (step_r != STEP_LAST) begin
                step_nxt = step_r + 4'd1;
              end
              nxt_d = step_lookup(layout_r, step_nxt);
              if (nxt_d.kind == K_STRBODY || nxt_d.kind == K_SEQBODY) begin
                rem_nxt = asm_new;
                if (asm_new == '0 && step_nxt != STEP_LAST) begin
                  step_nxt = step_nxt + 4'd1;
                end
              end
            end else begin
              sbi_nxt = sbi_r + 2'd1;
            end
          end
        end
        K_U8, K_BOOL: begin
          fld_emit = 1'b1;
          fld_code = cur.code;
          fld_val  = (cur.kind == K_BOOL) ? {31'd0, in_data.data_byte != 8'd0}
                                          : {24'd0, in_data.data_byte};
          if (step_r != STEP_LAST) begin
            step_nxt = step_r + 4'd1;
          end
        end
        K_STRBODY, K_SEQBODY: begin
          rem_nxt = rem_dec;
          // string terminator is the final byte, dropped
          if (cur.kind == K_SEQBODY || rem_dec != '0) begin
            fld_emit = 1'b1;
            fld_code = cur.code;
            fld_val  = {24'd0, in_data.data_byte};
          end
          if (rem_dec == '0 && step_r != STEP_LAST) begin
            step_nxt = step_r + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // end of message
    if (in_data.last_byte) begin
      nxt_d = step_lookup(layout_r, step_nxt);
      if (hdr_cnt_nxt < HEADER_LEN) begin
        status = ST_TRUNCATED;
      end else if (err_nxt) begin
        status = ST_NOT_LE;
      end else if (nxt_d.kind != K_DONE) begin
        status = ST_TRUNCATED;
      end else begin
        status = ST_OK;
      end
      hdr_cnt_nxt  = '0;
      body_off_nxt = '0;
      step_nxt     = '0;
      sbi_nxt      = '0;
      asm_nxt      = '0;
      rem_nxt      = '0;
      err_nxt      = 1'b0;
    end

    // pack results in order
    if (fld_emit) begin
      res0.field_code   = fld_code;
      res0.field_value  = fld_val;
      res0.parse_status = ST_OK;
      res0.run_last     = !in_data.last_byte;
      res1.field_code   = FC_END;
      res1.field_value  = '0;
      res1.parse_status = status;
      res1.run_last     = 1'b1;
      nres = in_data.last_byte ? 2'd2 : 2'd1;
    end else begin
      res0.field_code   = FC_END;
      res0.field_value  = '0;
      res0.parse_status = status;
      res0.run_last     = 1'b1;
      nres = in_data.last_byte ? 2'd1 : 2'd0;
    end
  end

  // result queue next state: shift on pop, then append
  always_comb begin
    logic [CW-1:0] base;
    base = cnt_r - CW'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (in_fire && nres != 2'd0 && base == CW'(i)) begin
        q_nxt[i] = res0;
      end
      if (in_fire && nres == 2'd2 && base + CW'(1) == CW'(i)) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = base + (in_fire ? CW'(nres) : CW'(0));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r   <= LAYOUT_RAW;
      hdr_cnt_r  <= '0;
      body_off_r <= '0;
      step_r     <= '0;
      sbi_r      <= '0;
      asm_r      <= '0;
      rem_r      <= '0;
      err_r      <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        layout_r <= cfg_wr_data;
      end
      if (in_fire) begin
        hdr_cnt_r  <= hdr_cnt_nxt;
        body_off_r <= body_off_nxt;
        step_r     <= step_nxt;
        sbi_r      <= sbi_nxt;
        asm_r      <= asm_nxt;
        rem_r      <= rem_nxt;
        err_r      <= err_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH))
    else $error("result queue overflow");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> hdr_cnt_r == '0 && step_r == '0 && !err_r)
    else $error("parse state not cleared after message end");

  a_sbi_body: assert property (@(posedge clk) disable iff (!rst_n)
    sbi_r != 2'd0 |-> hdr_cnt_r == HEADER_LEN && !err_r)
    else $error("scalar assembly outside accepted body");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && pop |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("queue count mismatch on pop");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.field_code == FC_END |-> out_data.run_last)
    else $error("end result without run_last");

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for cdr_le_message_deserializer_core: random cdr messages in, field results checked
// depends on cdrle_pkg and the core; field tracker class predicts every result transaction
`timescale 1ns / 1ps
module tb_top;
  import cdrle_pkg::*;

  localparam int RAND_BYTES = 1650;
  localparam int PHASES     = 8;

  // tracks the parse of the byte stream and holds the results still due
  class cdr_field_tracker;
    step_desc_t step_tab[4][16];
    logic [1:0] layout;
    logic [2:0] hdr_seen;
    logic [1:0] body_pos;
    logic [3:0] step_idx;
    logic [1:0] lane;
    logic [31:0] word;
    logic [31:0] left;
    logic err_flag;
    out_item_t due_fields[$];
    int errors;

    function new();
      int l, s;
      for (l = 0; l < 4; l++) begin
        for (s = 0; s < 16; s++) step_tab[l][s] = '{K_DONE, FC_SEC};
        step_tab[l][0] = '{K_U32, FC_SEC};
        step_tab[l][1] = '{K_U32, FC_NANOSEC};
        step_tab[l][2] = '{K_U32, FC_FRAME_LEN};
        step_tab[l][3] = '{K_STRBODY, FC_FRAME_CHR};
      end
      // raw image, also used for the spare layout code
      for (l = 0; l < 4; l += 3) begin
        step_tab[l][4]  = '{K_U32, FC_HEIGHT};
        step_tab[l][5]  = '{K_U32, FC_WIDTH};
        step_tab[l][6]  = '{K_U32, FC_ENC_LEN};
        step_tab[l][7]  = '{K_STRBODY, FC_ENC_CHR};
        step_tab[l][8]  = '{K_U8, FC_BIGENDIAN};
        step_tab[l][9]  = '{K_U32, FC_STEP};
        step_tab[l][10] = '{K_U32, FC_DATA_LEN};
        step_tab[l][11] = '{K_SEQBODY, FC_DATA_BYTE};
      end
      // h264 packet
      step_tab[1][4] = '{K_U32, FC_WIDTH};
      step_tab[1][5] = '{K_U32, FC_HEIGHT};
      step_tab[1][6] = '{K_BOOL, FC_KEYFRAME};
      step_tab[1][7] = '{K_U32, FC_DATA_LEN};
      step_tab[1][8] = '{K_SEQBODY, FC_DATA_BYTE};
      // compressed video
      step_tab[2][4] = '{K_U32, FC_DATA_LEN};
      step_tab[2][5] = '{K_SEQBODY, FC_DATA_BYTE};
      step_tab[2][6] = '{K_U32, FC_FMT_LEN};
      step_tab[2][7] = '{K_STRBODY, FC_FMT_CHR};
      layout = LAYOUT_RAW;
      errors = 0;
      clear_parse();
    endfunction

    function step_desc_t step_of(logic [1:0] l, logic [3:0] s);
      return step_tab[l][s];
    endfunction

    function void clear_parse();
      hdr_seen = '0;
      body_pos = '0;
      step_idx = '0;
      lane = '0;
      word = '0;
      left = '0;
      err_flag = 1'b0;
    endfunction

    function void next_step();
      if (step_idx != STEP_LAST) step_idx = step_idx + 4'd1;
    endfunction

    function out_item_t result_of(logic [3:0] fc, logic [31:0] v, logic [1:0] st);
      out_item_t r;
      r.field_code = fc;
      r.field_value = v;
      r.parse_status = st;
      r.run_last = 1'b0;
      return r;
    endfunction

    // predict the results of one accepted input transaction
    function void note_byte(in_item_t it);
      out_item_t made[$];
      step_desc_t d;
      step_kind_t nk;
      logic [7:0] b;
      logic [1:0] st;
      b = it.data_byte;
      if (hdr_seen < HEADER_LEN) begin
        if (hdr_seen == 3'd1 && b != LE_MARK) err_flag = 1'b1;
        hdr_seen = hdr_seen + 3'd1;
      end else if (!err_flag) begin
        d = step_tab[layout][step_idx];
        case (d.kind)
          K_U32: begin
            // padding before a word is skipped
            if (!(lane == 2'd0 && body_pos != 2'd0)) begin
              if (lane == 2'd0) word = {24'd0, b};
              else word = word | ({24'd0, b} << (8 * lane));
              if (lane == 2'd3) begin
                lane = 2'd0;
                made.push_back(result_of(d.code, word, ST_OK));
                next_step();
                nk = step_tab[layout][step_idx].kind;
                if (nk == K_STRBODY || nk == K_SEQBODY) begin
                  left = word;
                  if (left == 32'd0) next_step();
                end
              end else begin
                lane = lane + 2'd1;
              end
            end
          end
          K_U8: begin
            made.push_back(result_of(d.code, {24'd0, b}, ST_OK));
            next_step();
          end
          K_BOOL: begin
            made.push_back(result_of(d.code, (b != 8'd0) ? 32'd1 : 32'd0, ST_OK));
            next_step();
          end
          K_STRBODY, K_SEQBODY: begin
            // the final string byte is the terminator and is dropped
            left = left - 32'd1;
            if (d.kind == K_SEQBODY || left != 32'd0)
              made.push_back(result_of(d.code, {24'd0, b}, ST_OK));
            if (left == 32'd0) next_step();
          end
          default: ;
        endcase
        body_pos = body_pos + 2'd1;
      end
      if (it.last_byte) begin
        if (hdr_seen < HEADER_LEN) st = ST_TRUNCATED;
        else if (err_flag) st = ST_NOT_LE;
        else if (step_tab[layout][step_idx].kind != K_DONE) st = ST_TRUNCATED;
        else st = ST_OK;
        made.push_back(result_of(FC_END, 32'd0, st));
        clear_parse();
      end
      if (made.size() != 0) made[made.size() - 1].run_last = 1'b1;
      foreach (made[i]) due_fields.push_back(made[i]);
    endfunction

    function void flag(string what, logic [31:0] e, logic [31:0] a);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, e, a);
    endfunction

    // compare one result transaction with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (due_fields.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = due_fields.pop_front();
      if (got.field_code != want.field_code)
        flag("field_code", want.field_code, got.field_code);
      if (got.field_value != want.field_value)
        flag("field_value", want.field_value, got.field_value);
      if (got.parse_status != want.parse_status)
        flag("parse_status", want.parse_status, got.parse_status);
      if (got.run_last != want.run_last)
        flag("run_last", want.run_last, got.run_last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  cdr_field_tracker sb;
  logic [7:0] msg_bytes[$];
  bit idle_on = 1'b1;
  bit calm = 1'b0;
  int rand_bytes = 0;
  bit counting = 1'b0;

  always #4 clk = ~clk;

  cdr_le_message_deserializer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // result side: ready with random stall bursts
  initial begin : sink
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // hand one byte to the block and wait for the transaction
  task automatic push_byte(input logic [7:0] b, input logic l);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = l;
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(it);
    if (counting) rand_bytes++;
  endtask

  task automatic send_message(input int count, input bit close);
    int i;
    calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < count; i++) push_byte(msg_bytes[i], close && (i == count - 1));
  endtask

  // stop sending until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_layout(input logic [1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.layout = v;
    cfg_wr_en <= 1'b0;
  endtask

  // build one message into msg_bytes, mostly well formed
  task automatic build_message(input logic [1:0] lay);
    int s, i, n, mode, body_len, cut;
    logic [31:0] v;
    step_desc_t d, nd;
    bit stop;
    msg_bytes.delete();
    mode = $urandom_range(0, 99);
    v = '0;
    // noise and short messages
    if (mode >= 88) begin
      n = (mode >= 94) ? $urandom_range(1, 20) : $urandom_range(1, 3);
      repeat (n) msg_bytes.push_back(8'($urandom));
      return;
    end
    // encapsulation header, marker wrong now and then
    msg_bytes.push_back(8'($urandom));
    msg_bytes.push_back((mode >= 80) ? 8'($urandom_range(2, 256)) : LE_MARK);
    msg_bytes.push_back(8'($urandom));
    msg_bytes.push_back(8'($urandom));
    body_len = 0;
    stop = 1'b0;
    for (s = 0; s < 16 && !stop; s++) begin
      d = sb.step_of(lay, 4'(s));
      nd = sb.step_of(lay, 4'(s + 1));
      case (d.kind)
        K_U32: begin
          while (body_len % 4 != 0) begin
            msg_bytes.push_back(8'($urandom));
            body_len++;
          end
          if (nd.kind == K_STRBODY) v = $urandom_range(0, 6);
          else if (nd.kind == K_SEQBODY) v = $urandom_range(0, 10);
          else begin
            case ($urandom_range(0, 7))
              0: v = 32'h0000_0000;
              1: v = 32'hffff_ffff;
              2: v = 32'h8000_0000;
              3: v = 32'h7fff_ffff;
              default: v = $urandom;
            endcase
          end
          // an oversized length leaves the message cut short
          if ((nd.kind == K_STRBODY || nd.kind == K_SEQBODY) && $urandom_range(0, 19) == 0)
            v = $urandom;
          for (i = 0; i < 4; i++) msg_bytes.push_back(v[8*i +: 8]);
          body_len += 4;
          if ((nd.kind == K_STRBODY || nd.kind == K_SEQBODY) && v > 32'd64) stop = 1'b1;
        end
        K_U8, K_BOOL: begin
          msg_bytes.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'h00);
          body_len++;
        end
        K_STRBODY, K_SEQBODY: begin
          for (i = 0; i < int'(v); i++)
            msg_bytes.push_back((i == int'(v) - 1 && $urandom_range(0, 1)) ?
                                8'h00 : 8'($urandom));
          body_len += int'(v);
        end
        default: stop = 1'b1;
      endcase
    end
    // trailing bytes past the last field
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
    // message ends before its last field
    if (mode >= 70 && mode < 80 && msg_bytes.size() > 1) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endtask

  // main stimulus
  initial begin : stim
    int phase;
    logic [1:0] lay;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short message with a wrong marker, then a one byte message
    msg_bytes = '{8'h00, 8'h02};
    send_message(2, 1'b1);
    msg_bytes = '{8'hff};
    send_message(1, 1'b1);
    // rejected message, body ignored
    msg_bytes = '{8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00};
    send_message(6, 1'b1);
    // negative sec, then layout switch in mid message, nanosec ends it truncated
    msg_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
    send_message(8, 1'b0);
    wait_drained();
    write_layout(LAYOUT_H264);
    msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h80};
    send_message(4, 1'b1);

    // random phases, one layout each; the last phase runs without idling
    counting = 1'b1;
    for (phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase != PHASES - 1);
      lay = (phase < 4) ? 2'(3 - phase) : 2'($urandom_range(0, 3));
      wait_drained();
      write_layout(lay);
      while (rand_bytes < (phase + 1) * RAND_BYTES / PHASES) begin
        build_message(lay);
        send_message(msg_bytes.size(), 1'b1);
      end
      // sometimes leave a message open across the layout change
      if (phase < PHASES - 1 && $urandom_range(0, 2) == 0) begin
        build_message(lay);
        send_message(msg_bytes.size() / 2, 1'b0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due_fields.size() == 0) begin
      $display("cdr_le_message_deserializer_core test passed");
    end else begin
      $display("cdr_le_message_deserializer_core test failed");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #4000000;
    $display("cdr_le_message_deserializer_core test failed");
    $finish;
  end

endmodule
